>>> sv/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants of the delimiter-flag ring FIFO
// Request and result layouts, action codes and register indexes.
// ----------------------------------------------------------------------------
package rfd_pkg;

  // Default number of physical slots in the ring.
  localparam int RFD_DEPTH = 256;

  // Field widths fixed by the interface.
  localparam int DATA_W  = 8;
  localparam int CNT_W   = 9;
  localparam int ACT_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  // Action codes carried in a request.
  localparam logic [ACT_W-1:0] ACT_PUT      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SCAN_PUT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TAKE     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PEEK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] DELIM_RESET = 8'd10;

  // One request.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] data_in;
    logic [DATA_W-1:0] peek_offset;
  } in_t;

  // One result.
  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  free_space;
    logic              token_seen;
  } out_t;

endpackage

>>> sv/ring_fifo_with_delimiter_flag_unit.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_delimiter_flag_unit: byte ring FIFO with a delimiter flag
// Put, scan-put, take, peek and clear on a ring of byte slots in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_req) is taken at a rising edge with start high and busy
//   low. Every request is handled without a stall, so busy stays low and a
//   new request may be issued in every cycle: one request per clock.
//   The cursors, fill count and flag are updated at the accepting edge, and
//   the RAM read for take or peek is launched at that same edge.
//   The result appears on out_result with out_valid high in the cycle
//   after the request, for one cycle. The result is registered, and read data
//   comes from the registered read port of the slot RAM. The receiver cannot stall.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata while no
//   request is in flight; writing the capacity empties the FIFO and clears
//   the flag. Indexes beyond the register list are ignored.
//   Reset (rst_n low, synchronous) empties the FIFO, clears the flag and
//   loads the capacity with DEPTH, the delimiter with 10 and turns null
//   skipping off. Slot contents are not cleared; only written slots are read.
// ----------------------------------------------------------------------------
module ring_fifo_with_delimiter_flag_unit #(
  parameter int DEPTH = rfd_pkg::RFD_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  rfd_pkg::in_t                        in_req,
  output logic                                out_valid,
  output rfd_pkg::out_t                       out_result,
  input  logic                                cfg_we,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import rfd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Width that holds an index sum and the capacity without overflow.
  localparam int IW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  // Architectural state.
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]     wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              flag_r, flag_nxt;
  logic [CNT_W-1:0]  cap_cfg_r;
  logic [DATA_W-1:0] delim_r;
  logic              ignore_r;

  // Result staging.
  logic              out_valid_r;
  out_t              res_r, res_nxt;

  // RAM ports.
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_q;

  logic              req_acc;
  logic [CNT_W-1:0]  cap;
  logic [IW-1:0]     peek_sum;
  logic [AW-1:0]     peek_addr;

  // Cursor step with wrap at the capacity in use.
  function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] idx,
                                             input logic [CNT_W-1:0] c);
    logic [IW-1:0] n;
    n = IW'(idx) + IW'(1);
    return (n >= IW'(c)) ? '0 : n[AW-1:0];
  endfunction

  assign busy    = 1'b0;
  assign req_acc = start && !busy;

  // Effective capacity: zero acts as one, above DEPTH acts as DEPTH.
  always_comb begin
    if (cap_cfg_r == '0) begin
      cap = CNT_W'(1);
    end else if (32'(cap_cfg_r) > DEPTH) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = cap_cfg_r;
    end
  end

  // Peek position, wrapped once at the capacity.
  always_comb begin
    peek_sum = IW'(rd_idx_r) + IW'(in_req.peek_offset);
    if (peek_sum >= IW'(cap)) begin
      peek_sum = peek_sum - IW'(cap);
    end
    peek_addr = peek_sum[AW-1:0];
  end

  // Request decode and next state.
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    cnt_nxt    = cnt_r;
    flag_nxt   = flag_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rd_idx_r;
    res_nxt    = '0;
    if (req_acc) begin
      case (in_req.action)
        ACT_PUT: begin
          if (cnt_r < cap) begin
            ram_we             = 1'b1;
            res_nxt.accepted   = 1'b1;
          end
        end
        ACT_SCAN_PUT: begin
          if (cnt_r < cap) begin
            if (!(ignore_r && in_req.data_in == '0)) begin
              ram_we           = 1'b1;
              res_nxt.accepted = 1'b1;
            end
            if (in_req.data_in == delim_r) begin
              flag_nxt = 1'b1;
            end
          end
        end
        ACT_TAKE: begin
          if (cnt_r != '0) begin
            ram_re             = 1'b1;
            rd_idx_nxt         = step_idx(rd_idx_r, cap);
            cnt_nxt            = cnt_r - CNT_W'(1);
            flag_nxt           = 1'b0;
            res_nxt.accepted   = 1'b1;
            res_nxt.read_valid = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (CNT_W'(in_req.peek_offset) < cnt_r) begin
            ram_re             = 1'b1;
            ram_raddr          = peek_addr;
            res_nxt.accepted   = 1'b1;
            res_nxt.read_valid = 1'b1;
          end
        end
        ACT_CLEAR: begin
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          cnt_nxt    = '0;
          flag_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
      // A stored byte advances the write cursor and the count.
      if (ram_we) begin
        wr_idx_nxt = step_idx(wr_idx_r, cap);
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
    end
    res_nxt.fill_count = cnt_nxt;
    res_nxt.free_space = cap - cnt_nxt;
    res_nxt.token_seen = flag_nxt;
    // A capacity write restarts the ring empty.
    if (cfg_we && cfg_index == CFG_CAPACITY) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      cnt_nxt    = '0;
      flag_nxt   = 1'b0;
    end
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      cap_cfg_r   <= CNT_W'(DEPTH);
      delim_r     <= DELIM_RESET;
      ignore_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      cnt_r       <= cnt_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= req_acc;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY:  cap_cfg_r <= cfg_wdata[CNT_W-1:0];
          CFG_DELIMITER: delim_r   <= cfg_wdata[DATA_W-1:0];
          CFG_IGNORE:    ignore_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Slot storage.
  rfd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_req.data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Result assembly: read data comes straight from the RAM output.
  assign out_valid = out_valid_r;
  always_comb begin
    out_result           = res_r;
    out_result.read_data = res_r.read_valid ? ram_q : '0;
  end

`ifndef SYNTH
  // Every accepted request yields exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("missing result after accepted request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without request");

  // The fill count never exceeds the capacity in use.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap)
    else $error("fill count above capacity");

  // Both cursors stay inside the ring in use.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (IW'(wr_idx_r) < IW'(cap)) && (IW'(rd_idx_r) < IW'(cap)))
    else $error("cursor outside ring");

  // A take from a non-empty FIFO removes one entry and clears the flag.
  a_take_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we && in_req.action == ACT_TAKE && cnt_r != '0)
    |=> (cnt_r == $past(cnt_r) - CNT_W'(1)) && !flag_r)
    else $error("take did not remove an entry");
`endif

endmodule

>>> sv/rfd_ram.sv
// ----------------------------------------------------------------------------
// rfd_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> dv/ring_fifo_with_delimiter_flag_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_fifo_with_delimiter_flag_unit_tb: self-checking bench of the byte ring
// The bench drives put, scan-put, take, peek, clear and unused action codes
// under several capacity, delimiter and null-skip settings. A shadow copy of
// the ring predicts each status result, and every result is checked field by
// field in arrival order.
// ----------------------------------------------------------------------------
module ring_fifo_with_delimiter_flag_unit_tb;

  import rfd_pkg::*;

  // Shadow copy of the ring. It holds the slots, cursors, count and flag, and
  // the queue of status results still due from the block.
  class fifo_shadow;
    logic [DATA_W-1:0] slots [RFD_DEPTH];
    logic [CNT_W-1:0]  rd_ptr;
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  count;
    logic              flag;
    logic [CNT_W-1:0]  cap_reg;
    logic [DATA_W-1:0] delim;
    logic              ign_null;
    out_t              expected_status [$];
    int                n_err;
    int                n_checked;
    int                n_reads;
    int                n_full_rejects;
    int                n_flag_sets;

    function new();
      cap_reg  = CNT_W'(RFD_DEPTH);
      delim    = DELIM_RESET;
      ign_null = 1'b0;
      empty_ring();
    endfunction

    function void empty_ring();
      rd_ptr = '0;
      wr_ptr = '0;
      count  = '0;
      flag   = 1'b0;
    endfunction

    // Capacity as the block uses it: zero acts as one, oversize as the depth.
    function logic [CNT_W-1:0] eff_cap();
      if (cap_reg == '0) return CNT_W'(1);
      if (cap_reg > CNT_W'(RFD_DEPTH)) return CNT_W'(RFD_DEPTH);
      return cap_reg;
    endfunction

    function logic [CNT_W-1:0] next_ptr(logic [CNT_W-1:0] ptr);
      logic [CNT_W-1:0] nxt;
      nxt = ptr + CNT_W'(1);
      return (nxt >= eff_cap()) ? '0 : nxt;
    endfunction

    function void store_byte(logic [DATA_W-1:0] b);
      slots[wr_ptr[DATA_W-1:0]] = b;
      wr_ptr = next_ptr(wr_ptr);
      count  = count + CNT_W'(1);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CAPACITY: begin
          cap_reg = val;
          empty_ring();
        end
        CFG_DELIMITER: delim = val[DATA_W-1:0];
        CFG_IGNORE:    ign_null = val[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request to the shadow ring and queue its status.
    function void note_request(in_t req);
      out_t             exp;
      logic [CNT_W-1:0] cap;
      logic [CNT_W-1:0] idx;
      cap = eff_cap();
      exp = '0;
      case (req.action)
        ACT_PUT: begin
          if (count < cap) begin
            store_byte(req.data_in);
            exp.accepted = 1'b1;
          end else begin
            n_full_rejects++;
          end
        end
        ACT_SCAN_PUT: begin
          if (count < cap) begin
            // A dropped null byte still counts toward the delimiter match.
            if (!(ign_null && req.data_in == '0)) begin
              store_byte(req.data_in);
              exp.accepted = 1'b1;
            end
            if (req.data_in == delim) begin
              flag = 1'b1;
              n_flag_sets++;
            end
          end else begin
            n_full_rejects++;
          end
        end
        ACT_TAKE: begin
          if (count != '0) begin
            exp.read_data  = slots[rd_ptr[DATA_W-1:0]];
            rd_ptr         = next_ptr(rd_ptr);
            count          = count - CNT_W'(1);
            flag           = 1'b0;
            exp.accepted   = 1'b1;
            exp.read_valid = 1'b1;
            n_reads++;
          end
        end
        ACT_PEEK: begin
          if (CNT_W'(req.peek_offset) < count) begin
            idx = rd_ptr + CNT_W'(req.peek_offset);
            if (idx >= cap) idx = idx - cap;
            exp.read_data  = slots[idx[DATA_W-1:0]];
            exp.accepted   = 1'b1;
            exp.read_valid = 1'b1;
            n_reads++;
          end
        end
        ACT_CLEAR: empty_ring();
        default: ;
      endcase
      exp.fill_count = count;
      exp.free_space = cap - count;
      exp.token_seen = flag;
      expected_status.push_back(exp);
    endfunction

    function void cmp_field(string name, logic [CNT_W-1:0] e, logic [CNT_W-1:0] a);
      if (e !== a) begin
        $display("[%0t] mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
        n_err++;
      end
    endfunction

    // Compare one result from the block with the oldest status still due.
    function void check_result(out_t got);
      out_t exp;
      if (expected_status.size() == 0) begin
        $display("[%0t] result with nothing due: expected none, actual %p", $time, got);
        n_err++;
        return;
      end
      exp = expected_status.pop_front();
      n_checked++;
      cmp_field("accepted",   CNT_W'(exp.accepted),   CNT_W'(got.accepted));
      cmp_field("read_data",  CNT_W'(exp.read_data),  CNT_W'(got.read_data));
      cmp_field("read_valid", CNT_W'(exp.read_valid), CNT_W'(got.read_valid));
      cmp_field("fill_count", exp.fill_count,         got.fill_count);
      cmp_field("free_space", exp.free_space,         got.free_space);
      cmp_field("token_seen", CNT_W'(exp.token_seen), CNT_W'(got.token_seen));
    endfunction
  endclass

  // Action codes the block treats as no-ops, and a register index it ignores.
  localparam logic [ACT_W-1:0]     ACT_RSVD_FIRST = 3'd5;
  localparam logic [ACT_W-1:0]     ACT_RSVD_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD       = 2'd3;
  localparam int                   CYCLE_LIMIT    = 200000;
  localparam int                   N_PHASES       = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_t                   in_req = '0;
  logic                  out_valid;
  out_t                  out_result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  fifo_shadow ring;
  int         n_sent = 0;
  int         cycles = 0;
  bit         no_gaps = 1'b0;
  bit         fill_mode = 1'b1;

  ring_fifo_with_delimiter_flag_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is checked at once.
  always @(posedge clk) begin
    if (rst_n && out_valid) ring.check_result(out_result);
  end

  // Offer one request and wait for the edge that takes it.
  task automatic send_request(input in_t req);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy !== 1'b0);
    ring.note_request(req);
    n_sent++;
  endtask

  // Mostly back-to-back requests, some short pauses and a few long ones.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] data,
                       input logic [DATA_W-1:0] off);
    in_t req;
    req.action      = act;
    req.data_in     = data;
    req.peek_offset = off;
    send_request(req);
    idle_gap();
  endtask

  // Stop requesting and wait until every status due has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ring.expected_status.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    ring.set_reg(idx, val);
  endtask

  // All three registers; unused upper data bits carry random values.
  task automatic write_config(input logic [CNT_W-1:0] cap, input logic [DATA_W-1:0] delim,
                              input logic ign);
    logic [CFG_DATA_W-1:0] rnd;
    rnd = CFG_DATA_W'($urandom);
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_DELIMITER, {rnd[8], delim});
    write_reg(CFG_IGNORE, {rnd[7:0], ign});
    cfg_we <= 1'b0;
  endtask

  // Directed requests: boundaries, every action and each corner case.
  task automatic run_directed();
    // Default settings: empty reads, extreme bytes, delimiter, reserved codes.
    issue(ACT_TAKE, 8'h00, 8'h00);
    issue(ACT_PEEK, 8'h00, 8'h00);
    issue(ACT_PUT, 8'h00, 8'h00);
    issue(ACT_PUT, 8'hFF, 8'hFF);
    issue(ACT_SCAN_PUT, DELIM_RESET, 8'h00);
    issue(ACT_SCAN_PUT, 8'h00, 8'h00);
    issue(ACT_PEEK, 8'hAA, 8'd3);
    issue(ACT_PEEK, 8'h55, 8'd4);
    issue(ACT_PEEK, 8'h00, 8'hFF);
    issue(ACT_TAKE, 8'hFF, 8'h00);
    issue(ACT_RSVD_FIRST, 8'h12, 8'h00);
    issue(ACT_RSVD_FIRST + 3'd1, 8'h34, 8'h01);
    issue(ACT_RSVD_LAST, 8'hFF, 8'hFF);
    issue(ACT_CLEAR, 8'h00, 8'h00);
    issue(ACT_TAKE, 8'h00, 8'h00);
    drain();

    // Capacity written as zero acts as one slot: full ring rejects puts.
    write_config(9'd0, 8'hFF, 1'b0);
    issue(ACT_PUT, 8'h5A, 8'h00);
    issue(ACT_PUT, 8'hA5, 8'h00);
    issue(ACT_SCAN_PUT, 8'hFF, 8'h00);
    issue(ACT_PEEK, 8'h00, 8'h00);
    issue(ACT_TAKE, 8'h00, 8'h00);
    drain();

    // Oversize capacity, null skipping with a zero delimiter.
    write_reg(CFG_RSVD, 9'h1FF);
    write_config(9'd511, 8'h00, 1'b1);
    issue(ACT_SCAN_PUT, 8'h00, 8'h00);
    issue(ACT_TAKE, 8'h00, 8'h00);
    issue(ACT_SCAN_PUT, 8'h80, 8'h00);
    issue(ACT_CLEAR, 8'h00, 8'h00);
    drain();
  endtask

  function automatic logic [ACT_W-1:0] ACT_ACT_RSVD();
    return ACT_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
  endfunction

  // Random request shaped by the ring state: fill until full, then drain.
  task automatic random_request();
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] off;
    int                r;
    if (ring.count >= ring.eff_cap()) fill_mode = 1'b0;
    if (ring.count == '0) fill_mode = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 2) act = fill_mode ? ACT_PEEK : ACT_CLEAR;
    else if (r < 4) act = ACT_ACT_RSVD();
    else if (r < 18) act = ACT_PEEK;
    else if (fill_mode ? (r < 88) : (r < 31)) act = r[0] ? ACT_SCAN_PUT : ACT_PUT;
    else act = ACT_TAKE;

    r = $urandom_range(0, 99);
    if (act == ACT_SCAN_PUT && r < 25) data = ring.delim;
    else if (r < 35) data = 8'h00;
    else if (r < 42) data = 8'hFF;
    else data = DATA_W'($urandom);

    if (ring.count != '0 && $urandom_range(0, 9) < 7)
      off = DATA_W'($urandom_range(0, ring.count - 1));
    else
      off = DATA_W'($urandom);
    issue(act, data, off);
  endtask

  // Random phases, each under its own settings.
  task automatic run_random();
    logic [CNT_W-1:0]  cap;
    logic [DATA_W-1:0] delim;
    logic              ign;
    int                n_items;
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: cap = 9'd256;
        1: cap = 9'd1;
        2: cap = 9'd2;
        3: cap = 9'd0;
        4: cap = 9'd511;
        5: cap = 9'd300;
        6: cap = 9'd3;
        7: cap = 9'd255;
        default: cap = CNT_W'($urandom_range(4, 40));
      endcase
      delim   = (p == 1) ? 8'h00 : (p == 2) ? 8'hFF : DATA_W'($urandom);
      ign     = (p == 1) ? 1'b1 : (p == 2) ? 1'b0 : 1'($urandom);
      n_items = (p == 0) ? 330 : 40;
      no_gaps = ($urandom_range(0, 3) == 0);
      fill_mode = 1'b1;
      write_config(cap, delim, ign);
      repeat (n_items) random_request();
      drain();
    end
  endtask

  initial begin
    ring = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d requests, checked %0d results: %0d reads, %0d full rejects,",
             n_sent, ring.n_checked, ring.n_reads, ring.n_full_rejects);
    $display("%0d delimiter hits over %0d register settings.", ring.n_flag_sets,
             N_PHASES + 3);
    if (ring.n_err == 0 && ring.expected_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rfd_pkg.sv
sv/rfd_ram.sv
sv/ring_fifo_with_delimiter_flag_unit.sv
dv/ring_fifo_with_delimiter_flag_unit_tb.sv
